// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the RTL; they compile away under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Condition holds at every rising clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post, msg)
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg)

`endif

`endif

// ----- hdl/tfp_pkg.sv -----
// Types and constants of the tape-following PID steering core.
package tfp_pkg;

	// register map
	localparam int CfgAddrW = 5;
	localparam int CfgDataW = 32;

	typedef enum logic [2:0] {
		REG_PROP_GAIN   = 3'd0,
		REG_DERIV_GAIN  = 3'd1,
		REG_TAPE_THRESH = 3'd2,
		REG_INTEG_LIMIT = 3'd3,
		REG_STEER_LIMIT = 3'd4,
		REG_CRUISE      = 3'd5,
		REG_LEFT_TRIM   = 3'd6,
		REG_RIGHT_TRIM  = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] prop_gain;
		logic [15:0] deriv_gain;
		logic [11:0] tape_threshold;
		logic [23:0] integrator_limit;
		logic [11:0] steer_limit;
		logic [11:0] cruise_speed;
		logic [8:0]  left_trim;
		logic [8:0]  right_trim;
	} cfg_t;

	localparam cfg_t CfgReset = '{
		prop_gain:        16'd10000,
		deriv_gain:       16'd10000,
		tape_threshold:   12'd2048,
		integrator_limit: 24'd100000,
		steer_limit:      12'd1000,
		cruise_speed:     12'd2000,
		left_trim:        9'd256,
		right_trim:       9'd256
	};

	// error codes
	localparam int ErrW  = 4;
	localparam int JumpW = 5;
	localparam logic signed [ErrW-1:0] ErrZero    = 4'sd0;
	localparam logic signed [ErrW-1:0] ErrNegNear = -4'sd2;
	localparam logic signed [ErrW-1:0] ErrPosNear = 4'sd2;
	localparam logic signed [ErrW-1:0] ErrNegFar  = -4'sd5;
	localparam logic signed [ErrW-1:0] ErrPosFar  = 4'sd5;
	localparam logic SideLeft  = 1'b0;
	localparam logic SideRight = 1'b1;

	// arithmetic widths
	localparam int KiGain       = 35 * 10;
	localparam int DwellTickMs  = 100;
	localparam int SteerW       = 12;
	localparam int MulAW        = 17;
	localparam int MulBW        = 10;
	localparam int ProdW        = MulAW + MulBW;
	localparam int PropW        = 21;
	localparam int IntegW       = 26;
	localparam int IntegAccW    = 28;
	localparam int DerivQuotW   = 20;
	localparam int SumW         = 27;
	localparam int BaseW        = 14;
	localparam int TrimFracBits = 8;
	localparam int DwellW       = 26;
	localparam int TimeW        = 32;

	// 32-bit divide by DwellTickMs: q = (x * DwellRecip) >> DwellRecipShift
	localparam logic [TimeW-1:0] DwellRecip      = 32'h51EB_851F;
	localparam int               DwellRecipShift = 37;

	// serial divider
	localparam int DvdW     = 32;
	localparam int DivisorW = DwellW + 1;
	localparam int IterW    = 6;

	typedef struct packed {
		logic                start;
		logic [IterW-1:0]    iters;
		logic [DvdW-1:0]     dividend;
		logic [DivisorW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic            busy;
		logic            done;
		logic [DvdW-1:0] quotient;
	} div_rsp_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_P,
		ST_MUL_I,
		ST_INTEG,
		ST_MUL_D,
		ST_DIV_D,
		ST_SUM,
		ST_STEER,
		ST_MUL_L,
		ST_MUL_R,
		ST_DUTY_R,
		ST_DIV_T,
		ST_DONE
	} state_t;

endpackage

// ----- hdl/tfp_cfg_regs.sv -----
// APB register file holding the steering configuration.
module tfp_cfg_regs import tfp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [CfgAddrW-1:0] paddr,
	input  logic [CfgDataW-1:0] pwdata,
	output logic [CfgDataW-1:0] prdata,
	output logic                pready,
	output cfg_t                cfg
);

	reg_idx_t idx;
	cfg_t     cfg_q;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[CfgAddrW-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CfgReset;
		end else if (wr_en) begin
			unique case (idx)
				REG_PROP_GAIN:   cfg_q.prop_gain        <= pwdata[15:0];
				REG_DERIV_GAIN:  cfg_q.deriv_gain       <= pwdata[15:0];
				REG_TAPE_THRESH: cfg_q.tape_threshold   <= pwdata[11:0];
				REG_INTEG_LIMIT: cfg_q.integrator_limit <= pwdata[23:0];
				REG_STEER_LIMIT: cfg_q.steer_limit      <= pwdata[11:0];
				REG_CRUISE:      cfg_q.cruise_speed     <= pwdata[11:0];
				REG_LEFT_TRIM:   cfg_q.left_trim        <= pwdata[8:0];
				REG_RIGHT_TRIM:  cfg_q.right_trim       <= pwdata[8:0];
			endcase
		end
	end

	// readback
	always_comb begin
		unique case (idx)
			REG_PROP_GAIN:   prdata = CfgDataW'(cfg_q.prop_gain);
			REG_DERIV_GAIN:  prdata = CfgDataW'(cfg_q.deriv_gain);
			REG_TAPE_THRESH: prdata = CfgDataW'(cfg_q.tape_threshold);
			REG_INTEG_LIMIT: prdata = CfgDataW'(cfg_q.integrator_limit);
			REG_STEER_LIMIT: prdata = CfgDataW'(cfg_q.steer_limit);
			REG_CRUISE:      prdata = CfgDataW'(cfg_q.cruise_speed);
			REG_LEFT_TRIM:   prdata = CfgDataW'(cfg_q.left_trim);
			REG_RIGHT_TRIM:  prdata = CfgDataW'(cfg_q.right_trim);
		endcase
	end

endmodule

// ----- hdl/tfp_serial_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
module tfp_serial_div import tfp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [IterW-1:0]    cnt_q;
	logic                done_q;
	logic [DivisorW-1:0] rem_q;
	logic [DivisorW-1:0] dsr_q;
	logic [DvdW-1:0]     dvd_q;
	logic                busy;
	logic [DivisorW:0]   rem_sh;
	logic [DivisorW+1:0] diff;
	logic                fits;
	logic [DivisorW-1:0] rem_next;

	assign busy = (cnt_q != '0);

	// trial subtract of the shifted remainder
	always_comb begin
		rem_sh   = {rem_q, dvd_q[DvdW-1]};
		diff     = {1'b0, rem_sh} - {2'b00, dsr_q};
		fits     = !diff[DivisorW+1];
		rem_next = fits ? diff[DivisorW-1:0] : rem_sh[DivisorW-1:0];
	end

	// iteration count and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy && (cnt_q == IterW'(1));
			if (req.start) begin
				cnt_q <= req.iters;
			end else if (busy) begin
				cnt_q <= cnt_q - IterW'(1);
			end
		end
	end

	// quotient bits shift in where dividend bits shift out
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dsr_q <= req.divisor;
			dvd_q <= req.dividend;
		end else if (busy) begin
			rem_q <= rem_next;
			dvd_q <= {dvd_q[DvdW-2:0], fits};
		end
	end

	assign rsp.busy     = busy;
	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

endmodule

// ----- hdl/tfp_mul.sv -----
// Shared signed multiplier with a registered product.
module tfp_mul import tfp_pkg::*; (
	input  logic                    clk,
	input  logic signed [MulAW-1:0] a,
	input  logic signed [MulBW-1:0] b,
	output logic signed [ProdW-1:0] prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= ProdW'(a) * ProdW'(b);
	end

endmodule

// ----- hdl/tape_follow_pid_steering_core.sv -----
// Top level of the tape-following PID steering core: sequencer and datapath.
// Usage:
//   Input items arrive on s_tvalid/s_tready/s_tdata: two tape sensor samples
//   and a millisecond timestamp. For each item the core emits one result on
//   m_tvalid/m_tready/m_tdata: both wheel duties, the position error and the
//   clamped steering amount. Gains, limits and trims sit behind an APB port
//   and are to be written while the core is idle; the core does not enforce it.
//   One item at a time runs through a small sequencer that reuses one
//   registered multiplier and one serial divider; the derivative division
//   takes 20 iterations. When the error did not change, the elapsed time is
//   scaled to tenths of a second by a reciprocal multiply in the extra state ST_DIV_T.
//   s_tready is high only while the sequencer waits for an item in ST_IDLE, so
//   the next item is taken only once the previous one has left its last step.
//   The result sits in an output register; if the receiver stalls, the next
//   item is still taken and computed, and it waits at its last step until the
//   output register frees up.
//   Reset clears the integrator, error history and current dwell time, sets the
//   prior dwell to 1 and loads the default configuration; no result is pending after reset.
`include "assert_macros.svh"

module tape_follow_pid_steering_core import tfp_pkg::*; #(
	parameter int SAMPLE_BITS = 12,
	parameter int DUTY_BITS   = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	// APB configuration
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [CfgAddrW-1:0] paddr,
	input  logic [CfgDataW-1:0] pwdata,
	output logic [CfgDataW-1:0] prdata,
	output logic                pready,
	// input items
	input  logic                s_tvalid,
	output logic                s_tready,
	// left_sample, right_sample, now_ms (from bit 0 up), zero padded to bytes
	input  logic [((2*SAMPLE_BITS+TimeW+7)/8)*8-1:0] s_tdata,
	// result items
	output logic                m_tvalid,
	input  logic                m_tready,
	// left_duty, right_duty, track_error, steer_amount (from bit 0 up), zero padded
	output logic [((2*DUTY_BITS+ErrW+SteerW+7)/8)*8-1:0] m_tdata
);

	localparam int OutBusW   = ((2*DUTY_BITS+ErrW+SteerW+7)/8)*8;
	localparam int DutyFullW = ProdW - TrimFracBits;
	localparam int DwellProdW = 2*TimeW;
	localparam logic [DutyFullW-1:0] DutyMax = DutyFullW'((1 << DUTY_BITS) - 1);
	localparam logic [IterW-1:0] DerivIters = IterW'(DerivQuotW);

	cfg_t     cfg;
	div_req_t div_req;
	div_rsp_t div_rsp;

	state_t state_q, state_next;

	// sequencer-held PID state
	logic signed [ErrW-1:0]   err_q;
	logic signed [ErrW-1:0]   prev_err_q;
	logic                     last_side_q;
	logic signed [IntegW-1:0] integ_q;
	logic signed [JumpW-1:0]  jump_q;
	logic [DwellW-1:0]        prior_dwell_q;
	logic [DwellW-1:0]        cur_dwell_q;
	logic [TimeW-1:0]         change_time_q;
	logic                     m_tvalid_q;

	// per-item working registers
	logic [TimeW-1:0]             now_q;
	logic [TimeW-1:0]             elapsed_q;
	logic signed [PropW-1:0]      p_q;
	logic                         d_neg_q;
	logic signed [DerivQuotW:0]   d_q;
	logic signed [SumW-1:0]       sum_q;
	logic [SteerW-1:0]            steer_g_q;
	logic [DUTY_BITS-1:0]         duty_l_q;
	logic [DUTY_BITS-1:0]         duty_r_q;
	logic [DUTY_BITS-1:0]         out_duty_l_q;
	logic [DUTY_BITS-1:0]         out_duty_r_q;
	logic signed [ErrW-1:0]       out_err_q;
	logic [SteerW-1:0]            out_steer_q;

	// shared multiplier
	logic signed [MulAW-1:0] mul_a;
	logic signed [MulBW-1:0] mul_b;
	logic signed [ProdW-1:0] prod;

	// combinational helpers
	logic [SAMPLE_BITS-1:0]      in_left;
	logic [SAMPLE_BITS-1:0]      in_right;
	logic [TimeW-1:0]            in_now;
	logic [SAMPLE_BITS-1:0]      thresh;
	logic signed [ErrW-1:0]      err_new;
	logic                        side_new;
	logic                        accept;
	logic                        out_free;
	logic                        err_changed;
	logic signed [IntegAccW-1:0] integ_acc;
	logic signed [IntegAccW-1:0] integ_ext;
	logic signed [IntegAccW-1:0] lim_pos;
	logic signed [IntegAccW-1:0] lim_neg;
	logic [ProdW-1:0]            prod_mag;
	logic [DivisorW-1:0]         dwell_sum;
	logic [DivisorW-1:0]         dwell_div;
	logic [TimeW-1:0]            elapsed;
	logic [DwellProdW-1:0]       dwell_prod;
	logic [SumW-1:0]             sum_mag;
	logic signed [BaseW-1:0]     cruise_s;
	logic signed [BaseW-1:0]     steer_s;
	logic signed [BaseW-1:0]     base_l;
	logic signed [BaseW-1:0]     base_r;
	logic [BaseW-2:0]            clip_l;
	logic [BaseW-2:0]            clip_r;
	logic [DutyFullW-1:0]        duty_full;
	logic [DUTY_BITS-1:0]        duty_sat;
	logic [DerivQuotW-1:0]       d_mag;

	tfp_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tfp_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod)
	);

	tfp_serial_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// input fields
	assign in_left  = s_tdata[SAMPLE_BITS-1:0];
	assign in_right = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
	assign in_now   = s_tdata[2*SAMPLE_BITS+TimeW-1:2*SAMPLE_BITS];
	assign thresh   = SAMPLE_BITS'(cfg.tape_threshold);

	assign accept      = s_tvalid && s_tready;
	assign out_free    = !m_tvalid_q || m_tready;
	assign err_changed = (err_q != prev_err_q);

	// position error from the two sensors; equal-to-threshold keeps the old error
	always_comb begin
		err_new  = err_q;
		side_new = last_side_q;
		if (in_left > thresh && in_right > thresh) begin
			err_new = ErrZero;
		end else if (in_left < thresh && in_right > thresh) begin
			err_new  = ErrNegNear;
			side_new = SideLeft;
		end else if (in_left > thresh && in_right < thresh) begin
			err_new  = ErrPosNear;
			side_new = SideRight;
		end else if (in_left < thresh && in_right < thresh) begin
			err_new = (last_side_q == SideRight) ? ErrPosFar : ErrNegFar;
		end
	end

	// integrator clamp
	assign integ_ext = IntegAccW'(integ_q);
	assign integ_acc = integ_ext + IntegAccW'(prod);
	assign lim_pos   = $signed({{(IntegAccW-24){1'b0}}, cfg.integrator_limit});
	assign lim_neg   = -lim_pos;

	// derivative operands
	assign prod_mag  = prod[ProdW-1] ? ProdW'(-prod) : ProdW'(prod);
	assign dwell_sum = {1'b0, prior_dwell_q} + {1'b0, cur_dwell_q};
	assign dwell_div = (dwell_sum == '0) ? DivisorW'(1) : dwell_sum;
	assign elapsed   = now_q - change_time_q;
	assign d_mag     = div_rsp.quotient[DerivQuotW-1:0];

	// elapsed ms to tenths of a second by reciprocal multiply
	assign dwell_prod = DwellProdW'(elapsed_q) * DwellProdW'(DwellRecip);

	// steering magnitude and wheel bases
	assign sum_mag  = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);
	assign cruise_s = $signed({2'b00, cfg.cruise_speed});
	assign steer_s  = $signed({2'b00, steer_g_q});

	always_comb begin
		if (err_q < 0) begin
			base_l = cruise_s + steer_s;
			base_r = cruise_s - steer_s;
		end else if (err_q > 0) begin
			base_l = cruise_s - steer_s;
			base_r = cruise_s + steer_s;
		end else begin
			base_l = cruise_s;
			base_r = cruise_s;
		end
	end

	assign clip_l = (base_l > 0) ? base_l[BaseW-2:0] : '0;
	assign clip_r = (base_r > 0) ? base_r[BaseW-2:0] : '0;

	// trimmed duty, Q8 scale then saturate
	assign duty_full = prod[ProdW-1:TrimFracBits];
	assign duty_sat  = (duty_full > DutyMax) ? DutyMax[DUTY_BITS-1:0]
	                                         : duty_full[DUTY_BITS-1:0];

	// next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE:   if (s_tvalid) state_next = ST_MUL_P;
			ST_MUL_P:  state_next = ST_MUL_I;
			ST_MUL_I:  state_next = ST_INTEG;
			ST_INTEG:  state_next = ST_MUL_D;
			ST_MUL_D:  state_next = ST_DIV_D;
			ST_DIV_D:  if (div_rsp.done) state_next = ST_SUM;
			ST_SUM:    state_next = ST_STEER;
			ST_STEER:  state_next = ST_MUL_L;
			ST_MUL_L:  state_next = ST_MUL_R;
			ST_MUL_R:  state_next = ST_DUTY_R;
			ST_DUTY_R: state_next = err_changed ? ST_DONE : ST_DIV_T;
			ST_DIV_T:  state_next = ST_DONE;
			ST_DONE:   if (out_free) state_next = ST_IDLE;
			default:   state_next = ST_IDLE;
		endcase
	end

	// sequencer outputs: handshake, multiplier operands, divider requests
	always_comb begin
		s_tready         = 1'b0;
		mul_a            = '0;
		mul_b            = '0;
		div_req.start    = 1'b0;
		div_req.iters    = DerivIters;
		div_req.dividend = '0;
		div_req.divisor  = dwell_div;
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_MUL_P: begin
				mul_a = $signed({1'b0, cfg.prop_gain});
				mul_b = MulBW'(err_q);
			end
			ST_MUL_I: begin
				mul_a = MulAW'(KiGain);
				mul_b = MulBW'(err_q);
			end
			ST_INTEG: begin
				mul_a = $signed({1'b0, cfg.deriv_gain});
				mul_b = MulBW'(jump_q);
			end
			ST_MUL_D: begin
				div_req.start    = 1'b1;
				div_req.dividend = {prod_mag[DerivQuotW-1:0], {(DvdW-DerivQuotW){1'b0}}};
			end
			ST_MUL_L: begin
				mul_a = $signed(MulAW'(clip_l));
				mul_b = $signed({1'b0, cfg.left_trim});
			end
			ST_MUL_R: begin
				mul_a = $signed(MulAW'(clip_r));
				mul_b = $signed({1'b0, cfg.right_trim});
			end
			default: ;
		endcase
	end

	// PID state and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			err_q         <= ErrZero;
			prev_err_q    <= ErrZero;
			last_side_q   <= SideLeft;
			integ_q       <= '0;
			jump_q        <= '0;
			prior_dwell_q <= DwellW'(1);
			cur_dwell_q   <= '0;
			change_time_q <= '0;
			m_tvalid_q    <= 1'b0;
		end else begin
			state_q <= state_next;
			if (accept) begin
				err_q       <= err_new;
				last_side_q <= side_new;
			end
			if (state_q == ST_INTEG) begin
				if (integ_acc > lim_pos) begin
					integ_q <= IntegW'(lim_pos);
				end else if (integ_acc < lim_neg) begin
					integ_q <= IntegW'(lim_neg);
				end else begin
					integ_q <= IntegW'(integ_acc);
				end
			end
			// dwell bookkeeping after the output is formed
			if (state_q == ST_DUTY_R) begin
				prev_err_q <= err_q;
				if (err_changed) begin
					jump_q        <= JumpW'(err_q) - JumpW'(prev_err_q);
					change_time_q <= now_q;
					prior_dwell_q <= cur_dwell_q;
					cur_dwell_q   <= '0;
				end
			end
			if (state_q == ST_DIV_T) begin
				cur_dwell_q <= dwell_prod[DwellRecipShift +: DwellW];
			end
			// output register handshake
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// datapath working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			now_q <= in_now;
		end
		if (state_q == ST_MUL_I) begin
			p_q <= PropW'(prod);
		end
		if (state_q == ST_MUL_D) begin
			d_neg_q <= prod[ProdW-1];
		end
		if (state_q == ST_DIV_D && div_rsp.done) begin
			d_q <= d_neg_q ? -$signed({1'b0, d_mag}) : $signed({1'b0, d_mag});
		end
		if (state_q == ST_SUM) begin
			sum_q <= SumW'(p_q) + SumW'(integ_q) + SumW'(d_q);
		end
		if (state_q == ST_STEER) begin
			steer_g_q <= (sum_mag > SumW'(cfg.steer_limit)) ? cfg.steer_limit
			                                                 : sum_mag[SteerW-1:0];
		end
		if (state_q == ST_MUL_R) begin
			duty_l_q <= duty_sat;
		end
		if (state_q == ST_DUTY_R) begin
			duty_r_q  <= duty_sat;
			elapsed_q <= elapsed;
		end
		if (state_q == ST_DONE && out_free) begin
			out_duty_l_q <= duty_l_q;
			out_duty_r_q <= duty_r_q;
			out_err_q    <= err_q;
			out_steer_q  <= steer_g_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OutBusW'({out_steer_q, out_err_q, out_duty_r_q, out_duty_l_q});

	// checks
	`ASSERT_NEXT(a_accept_starts_seq, clk, arst_n, s_tvalid && s_tready, state_q == ST_MUL_P, "accepted item did not start the sequencer")
	`ASSERT_IMPLIES(a_div_start_free, clk, arst_n, div_req.start, !div_rsp.busy, "divider started while busy")
	`ASSERT_NEXT(a_integ_in_limit, clk, arst_n, state_q == ST_INTEG, (integ_ext <= lim_pos) && (integ_ext >= lim_neg), "integrator outside its clamp")
	`ASSERT_IMPLIES(a_steer_in_limit, clk, arst_n, m_tvalid, out_steer_q <= cfg.steer_limit, "steer amount above steer limit")

endmodule

// ----- tb/tb_tape_follow_pid_steering_core.sv -----
// Self-checking testbench for the tape-following PID steering core.
module tb_tape_follow_pid_steering_core import tfp_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int  InW       = 56;
	localparam int  OutW      = 40;
	localparam int  DrainWait = 70;
	localparam int  CycleCap  = 1000000;
	localparam int  NumProbes = 18;

	// result fields, last field in the top bits as on m_tdata
	typedef struct packed {
		logic [11:0]            steer_amount;
		logic signed [ErrW-1:0] track_error;
		logic [11:0]            right_duty;
		logic [11:0]            left_duty;
	} steer_result_t;

	typedef struct {
		logic [11:0]   left_sample;
		logic [11:0]   right_sample;
		logic [31:0]   now_ms;
		bit            pinned;
		steer_result_t want;
	} probe_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [CfgAddrW-1:0] paddr;
	logic [CfgDataW-1:0] pwdata;
	logic [CfgDataW-1:0] prdata;
	logic                pready;
	logic                s_tvalid;
	logic                s_tready;
	logic [InW-1:0]      s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [OutW-1:0]     m_tdata;

	// predictor copy of registers and loop state
	cfg_t                   steer_cfg   = CfgReset;
	logic                   hold_side   = SideLeft;
	logic signed [ErrW-1:0] err_now     = ErrZero;
	logic signed [ErrW-1:0] err_prev    = ErrZero;
	longint                 integ_acc   = 0;
	logic signed [JumpW-1:0] err_step   = '0;
	logic [31:0]            dwell_prior = 32'd1;
	logic [31:0]            dwell_now   = 32'd0;
	logic [31:0]            change_ms   = 32'd0;

	steer_result_t pending_steer[$];
	probe_row_t    probe_rows[NumProbes];
	bit            pin_next = 1'b0;
	steer_result_t pin_want;
	bit            calm = 1'b0;
	logic [31:0]   ms_clock = 32'd0;
	int            mismatch_count = 0;
	int            cycle_count = 0;
	int            stall_left = 0;

	tape_follow_pid_steering_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #4 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleCap) begin
			$display("tape_follow_pid_steering_core verification failed");
			$finish;
		end
	end

	task automatic note_mismatch(input string what, input longint got, input longint want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	function automatic logic [11:0] scale_duty(input longint base, input logic [8:0] trim);
		longint v;
		if (base <= 0)
			return 12'd0;
		v = (base * longint'(trim)) >>> TrimFracBits;
		return (v > 4095) ? 12'd4095 : 12'(v);
	endfunction

	// one control step: error decode, PID, clamp, wheel duties, dwell bookkeeping
	function automatic steer_result_t predict_steering(input logic [11:0] ls,
			input logic [11:0] rs, input logic [31:0] now);
		steer_result_t r;
		logic [11:0]   th;
		longint        e, p, d, g, dv, lim, acc, base_l, base_r;
		logic [31:0]   span;
		th = steer_cfg.tape_threshold;
		if (ls > th && rs > th) begin
			err_now = ErrZero;
		end else if (ls < th && rs > th) begin
			err_now = ErrNegNear;
			hold_side = SideLeft;
		end else if (ls > th && rs < th) begin
			err_now = ErrPosNear;
			hold_side = SideRight;
		end else if (ls < th && rs < th) begin
			err_now = (hold_side == SideRight) ? ErrPosFar : ErrNegFar;
		end
		// a sample sitting on the threshold leaves error and side alone
		e = err_now;
		p = longint'(steer_cfg.prop_gain) * e;
		dv = longint'(dwell_prior) + longint'(dwell_now);
		if (dv == 0)
			dv = 1;
		d = (longint'(steer_cfg.deriv_gain) * longint'(err_step)) / dv;
		lim = longint'(steer_cfg.integrator_limit);
		acc = integ_acc + longint'(KiGain) * e;
		if (acc > lim)
			acc = lim;
		else if (acc < -lim)
			acc = -lim;
		integ_acc = acc;
		g = p + integ_acc + d;
		if (g < 0)
			g = -g;
		if (g > longint'(steer_cfg.steer_limit))
			g = longint'(steer_cfg.steer_limit);
		base_l = longint'(steer_cfg.cruise_speed);
		base_r = base_l;
		if (e < 0) begin
			base_l += g;
			base_r -= g;
		end else if (e > 0) begin
			base_l -= g;
			base_r += g;
		end
		r.left_duty    = scale_duty(base_l, steer_cfg.left_trim);
		r.right_duty   = scale_duty(base_r, steer_cfg.right_trim);
		r.track_error  = err_now;
		r.steer_amount = 12'(g);
		// dwell times in tenths of a second, time difference wraps at 32 bits
		if (err_now != err_prev) begin
			err_step = JumpW'(longint'(err_now) - longint'(err_prev));
			change_ms = now;
			dwell_prior = dwell_now;
			dwell_now = 32'd0;
		end else begin
			span = now - change_ms;
			dwell_now = span / 32'(DwellTickMs);
		end
		err_prev = err_now;
		return r;
	endfunction

	// accepted items and results, sampled at the rising edge
	always @(posedge clk) begin
		steer_result_t got, want, pred;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = steer_result_t'(m_tdata);
				if (pending_steer.size() == 0) begin
					note_mismatch("result with none expected", 0, 0);
				end else begin
					want = pending_steer.pop_front();
					if (got.left_duty != want.left_duty)
						note_mismatch("left_duty", got.left_duty, want.left_duty);
					if (got.right_duty != want.right_duty)
						note_mismatch("right_duty", got.right_duty, want.right_duty);
					if (got.track_error != want.track_error)
						note_mismatch("track_error", got.track_error, want.track_error);
					if (got.steer_amount != want.steer_amount)
						note_mismatch("steer_amount", got.steer_amount, want.steer_amount);
				end
			end
			if (s_tvalid && s_tready) begin
				pred = predict_steering(s_tdata[11:0], s_tdata[23:12], s_tdata[55:24]);
				pending_steer.push_back(pin_next ? pin_want : pred);
			end
		end
	end

	// receiver stalls: mostly short, a few long
	initial begin
		int r;
		forever begin
			@(negedge clk);
			if (calm || !arst_n) begin
				m_tready = arst_n;
				stall_left = 0;
			end else if (stall_left > 0) begin
				m_tready = 1'b0;
				stall_left--;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					m_tready = 1'b1;
				end else begin
					m_tready = 1'b0;
					stall_left = (r < 95) ? $urandom_range(0, 4) : $urandom_range(20, 90);
				end
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 70);
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic push_item(input logic [InW-1:0] d);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = d;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		s_tvalid = 1'b0;
		while (pending_steer.size() != 0)
			@(negedge clk);
		repeat (DrainWait) @(negedge clk);
	endtask

	function automatic logic [31:0] setting_value(input cfg_t c, input reg_idx_t idx);
		case (idx)
			REG_PROP_GAIN:   return 32'(c.prop_gain);
			REG_DERIV_GAIN:  return 32'(c.deriv_gain);
			REG_TAPE_THRESH: return 32'(c.tape_threshold);
			REG_INTEG_LIMIT: return 32'(c.integrator_limit);
			REG_STEER_LIMIT: return 32'(c.steer_limit);
			REG_CRUISE:      return 32'(c.cruise_speed);
			REG_LEFT_TRIM:   return 32'(c.left_trim);
			default:         return 32'(c.right_trim);
		endcase
	endfunction

	task automatic store_setting(input reg_idx_t idx, input logic [31:0] val);
		case (idx)
			REG_PROP_GAIN:   steer_cfg.prop_gain        = val[15:0];
			REG_DERIV_GAIN:  steer_cfg.deriv_gain       = val[15:0];
			REG_TAPE_THRESH: steer_cfg.tape_threshold   = val[11:0];
			REG_INTEG_LIMIT: steer_cfg.integrator_limit = val[23:0];
			REG_STEER_LIMIT: steer_cfg.steer_limit      = val[11:0];
			REG_CRUISE:      steer_cfg.cruise_speed     = val[11:0];
			REG_LEFT_TRIM:   steer_cfg.left_trim        = val[8:0];
			default:         steer_cfg.right_trim       = val[8:0];
		endcase
	endtask

	// APB write: setup cycle, then access cycle
	task automatic apb_write(input reg_idx_t idx, input logic [31:0] val);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		store_setting(idx, val);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic load_settings(input cfg_t c);
		wait_idle();
		for (int i = 0; i < 8; i++)
			apb_write(reg_idx_t'(i), setting_value(c, reg_idx_t'(i)));
	endtask

	function automatic cfg_t random_settings();
		cfg_t c;
		c.prop_gain        = 16'($urandom_range(0, 40950));
		c.deriv_gain       = 16'($urandom_range(0, 40950));
		c.tape_threshold   = 12'($urandom_range(0, 4095));
		c.integrator_limit = ($urandom_range(0, 3) == 0) ? 24'($urandom_range(0, 16777215))
			: 24'($urandom_range(0, 200000));
		c.steer_limit      = 12'($urandom_range(0, 4095));
		c.cruise_speed     = 12'($urandom_range(0, 4095));
		c.left_trim        = 9'($urandom_range(0, 511));
		c.right_trim       = 9'($urandom_range(0, 511));
		return c;
	endfunction

	// sample above, below, on, or anywhere around the threshold
	function automatic logic [11:0] pick_sample(input logic [11:0] th);
		int k;
		k = $urandom_range(0, 9);
		if (k < 4 && th != 12'hFFF)
			return 12'(th + 1 + $urandom_range(0, 4094 - th));
		if (k < 8 && th != 12'h000)
			return 12'($urandom_range(0, th - 1));
		if (k == 8)
			return th;
		return 12'($urandom_range(0, 4095));
	endfunction

	task automatic run_random(input int count);
		int r;
		pin_next = 1'b0;
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < 3)
				ms_clock = $urandom();
			else if (r >= 8)
				ms_clock += 32'($urandom_range(1, 600));
			push_item({ms_clock, pick_sample(steer_cfg.tape_threshold),
				pick_sample(steer_cfg.tape_threshold)});
		end
	endtask

	initial begin
		cfg_t c;
		// defaults: threshold 2048, steer limit 1000, cruise 2000, unity trims
		probe_rows = '{
			'{12'd4095, 12'd4095, 32'd0, 1'b1, '{12'd0, ErrZero, 12'd2000, 12'd2000}},
			'{12'd0, 12'd0, 32'd0, 1'b1, '{12'd1000, ErrNegFar, 12'd1000, 12'd3000}},
			'{12'd2048, 12'd2048, 32'd150, 1'b0, '0},
			'{12'd0, 12'd4095, 32'd300, 1'b0, '0},
			'{12'd4095, 12'd0, 32'd400, 1'b0, '0},
			'{12'd0, 12'd0, 32'd400, 1'b0, '0},
			'{12'd4095, 12'd0, 32'd400, 1'b0, '0},
			'{12'd2049, 12'd2047, 32'd950, 1'b0, '0},
			'{12'd2047, 12'd2049, 32'd1700, 1'b0, '0},
			'{12'd2048, 12'd4095, 32'd2500, 1'b0, '0},
			'{12'd4095, 12'd2048, 32'd2600, 1'b0, '0},
			'{12'd0, 12'd2048, 32'd2700, 1'b0, '0},
			'{12'd4095, 12'd4095, 32'hFFFF_FFF0, 1'b0, '0},
			'{12'd4095, 12'd4095, 32'h0000_0100, 1'b0, '0},
			'{12'd0, 12'd0, 32'hFFFF_FFFF, 1'b0, '0},
			'{12'd0, 12'd0, 32'h0000_2000, 1'b0, '0},
			'{12'hAAA, 12'h555, 32'hAAAA_AAAA, 1'b0, '0},
			'{12'h555, 12'hAAA, 32'h5555_5555, 1'b0, '0}
		};
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed items under reset settings
		foreach (probe_rows[i]) begin
			pin_next = probe_rows[i].pinned;
			pin_want = probe_rows[i].want;
			push_item({probe_rows[i].now_ms, probe_rows[i].right_sample,
				probe_rows[i].left_sample});
		end
		ms_clock = 32'h0000_3000;
		run_random(110);
		// sender holds off until every result is back
		wait_idle();
		run_random(110);

		// random settings, first stretch with no idling
		load_settings(random_settings());
		calm = 1'b1;
		run_random(70);
		calm = 1'b0;
		run_random(80);

		// everything at the top of its range
		c = '{prop_gain: 16'd40950, deriv_gain: 16'd40950, tape_threshold: 12'd4095,
			integrator_limit: 24'hFF_FFFF, steer_limit: 12'd4095, cruise_speed: 12'd4095,
			left_trim: 9'd511, right_trim: 9'd511};
		load_settings(c);
		run_random(100);

		// integrator limit dropped below the accumulated sum
		c = random_settings();
		c.integrator_limit = 24'd1000;
		c.tape_threshold = 12'd2048;
		load_settings(c);
		run_random(80);

		// everything at zero
		load_settings('0);
		run_random(60);

		// time counter close to wrap, then several random settings
		ms_clock = 32'hFFFF_F000;
		repeat (3) begin
			load_settings(random_settings());
			run_random(80);
		end
		load_settings(CfgReset);
		run_random(40);

		wait_idle();
		if (mismatch_count == 0)
			$display("tape_follow_pid_steering_core verification clean");
		else
			$display("tape_follow_pid_steering_core verification failed");
		$finish;
	end

endmodule
